FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: src/nfrc_pkg.sv
// ----------------------------------------------------------------------------
// nfrc_pkg
// Widths, limits and shared types of the nearest frame rate converter.
// ----------------------------------------------------------------------------
`default_nettype none

package nfrc_pkg;

	localparam int unsigned FRAME_W          = 32;
	localparam int unsigned RATE_W           = 19;
	localparam int unsigned LEN_W            = 13;
	localparam int unsigned CNT_W            = 13;
	localparam int unsigned ERR_W            = 22;
	localparam int unsigned PROD_W           = CNT_W + RATE_W;

	localparam int unsigned MAX_BLOCK_FRAMES = 4096;
	localparam int unsigned MAX_REPEATS      = 64;
	localparam int unsigned REP_W            = $clog2(MAX_REPEATS + 1);

	// Queue depths must be powers of two (pointers wrap freely).
	localparam int unsigned CMDQ_DEPTH       = 2;
	localparam int unsigned CMDQ_PTR_W       = $clog2(CMDQ_DEPTH);
	localparam int unsigned RESQ_DEPTH       = 4;
	localparam int unsigned RESQ_PTR_W       = $clog2(RESQ_DEPTH);

	localparam logic [LEN_W-1:0] LEN_CAP      = LEN_W'(MAX_BLOCK_FRAMES);
	localparam logic [CNT_W-1:0] IN_COUNT_MAX = '1;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_IN_RATE      = 2'd0,
		REG_OUT_RATE     = 2'd1,
		REG_BLOCK_FRAMES = 2'd2
	} cfg_reg_t;

	typedef logic [RATE_W-1:0] rate_t;

	typedef struct packed {
		rate_t             in_rate;
		rate_t             out_rate;
		logic [LEN_W-1:0]  block_frames;
	} cfg_t;

	// One accepted input, classified by the front end.
	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic               block_start;
		logic               down;     // out_rate < in_rate
		logic               no_out;   // out_rate == 0
	} cmd_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic               run_last;
		logic               block_done;
		logic [CNT_W-1:0]   consumed;
	} result_t;

endpackage

`default_nettype wire

FILE: src/nfrc_front.sv
// ----------------------------------------------------------------------------
// nfrc_front
// Input side: takes frames, tags them with the conversion direction and
// holds them in a short command queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module nfrc_front import nfrc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [FRAME_W-1:0] frame,
	input  wire logic               block_start,
	input  wire cfg_t               cfg,
	output logic                    cmd_valid,
	output cmd_t                    cmd,
	input  wire logic               cmd_pop
);

	cmd_t                  mem_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_PTR_W:0]   count_q;
	cmd_t                  new_cmd;
	logic                  do_push;
	logic                  do_pop;

	assign full      = (count_q == (CMDQ_PTR_W + 1)'(CMDQ_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;
	assign cmd       = mem_q[rd_ptr_q];

	always_comb begin
		new_cmd.frame       = frame;
		new_cmd.block_start = block_start;
		new_cmd.down        = (cfg.out_rate < cfg.in_rate);
		new_cmd.no_out      = (cfg.out_rate == '0);
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/nfrc_back.sv
// ----------------------------------------------------------------------------
// nfrc_back
// Execution side: keeps the block state (error term, counters, finished)
// and turns each command into zero or more output frames.
// ----------------------------------------------------------------------------
`default_nettype none

module nfrc_back import nfrc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic      cmd_pop,
	input  wire logic res_full,
	output logic      res_push,
	output result_t   res
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_CHECK} state_t;

	state_t                    state_q;
	logic signed [ERR_W-1:0]   err_q;
	logic [CNT_W-1:0]          oc_q;
	logic [CNT_W-1:0]          ic_q;
	logic                      fin_q;
	logic [REP_W-1:0]          reps_q;
	logic [FRAME_W-1:0]        frame_q;
	logic [PROD_W-1:0]         pa_q;
	logic [PROD_W-1:0]         pb_q;

	logic [LEN_W-1:0]          len;
	logic                      eff_fin;
	logic [CNT_W-1:0]          eff_oc;
	logic [CNT_W-1:0]          eff_ic;
	logic signed [RATE_W+1:0]  start_diff;
	logic signed [ERR_W-1:0]   start_err;
	logic                      skip;

	logic                      adv;
	logic signed [ERR_W:0]     two_in;
	logic signed [ERR_W:0]     two_out;
	logic signed [ERR_W:0]     step_v;
	logic signed [ERR_W:0]     sum_v;
	logic signed [ERR_W-1:0]   err_next;
	logic [CNT_W-1:0]          oc_next;
	logic [REP_W-1:0]          reps_next;
	logic                      run_end;
	logic [CNT_W-1:0]          ic_next;
	logic                      run_done;
	logic                      run_last;

	logic                      match;
	logic                      chk_done;

	function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
		return (v == IN_COUNT_MAX) ? v : v + 1'b1;
	endfunction

	// Block start takes effect before the frame is used.
	always_comb begin
		len        = (cfg.block_frames > LEN_CAP) ? LEN_CAP : cfg.block_frames;
		eff_fin    = cmd.block_start ? 1'b0 : fin_q;
		eff_oc     = cmd.block_start ? '0 : oc_q;
		eff_ic     = cmd.block_start ? '0 : ic_q;
		start_diff = $signed({1'b0, cfg.in_rate, 1'b0}) - $signed({2'b00, cfg.out_rate});
		start_err  = {{(ERR_W - RATE_W - 2){start_diff[RATE_W+1]}}, start_diff};
		skip       = eff_fin || (len == '0) || ({{(CNT_W - LEN_W){1'b0}}, len} <= eff_oc);
	end

	// One output per cycle while repeating and the result queue is not full: error term update with clamp.
	always_comb begin
		adv       = !err_q[ERR_W-1];
		two_in    = {{(ERR_W - RATE_W){1'b0}}, cfg.in_rate, 1'b0};
		two_out   = {{(ERR_W - RATE_W){1'b0}}, cfg.out_rate, 1'b0};
		step_v    = adv ? (two_in - two_out) : two_in;
		sum_v     = {err_q[ERR_W-1], err_q} + step_v;
		err_next  = (sum_v[ERR_W] == sum_v[ERR_W-1]) ? sum_v[ERR_W-1:0]
			: {sum_v[ERR_W], {(ERR_W - 1){~sum_v[ERR_W]}}};
		oc_next   = oc_q + 1'b1;
		reps_next = reps_q + 1'b1;
		run_end   = adv || (reps_next >= REP_W'(MAX_REPEATS));
		ic_next   = run_end ? inc_sat(ic_q) : ic_q;
		run_done  = ({{(CNT_W - LEN_W){1'b0}}, len} <= oc_next);
		run_last  = run_end || run_done;
	end

	// Downsampling: in_count is the target iff
	// in_count*out_rate <= out_count*in_rate < (in_count+1)*out_rate.
	always_comb begin
		match    = (pb_q <= pa_q) && ((pa_q - pb_q) < PROD_W'(cfg.out_rate));
		chk_done = ({{(CNT_W - LEN_W){1'b0}}, len} <= oc_next);
	end

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;

	always_comb begin
		res_push = 1'b0;
		res      = '0;
		res.frame = frame_q;
		unique case (state_q)
			ST_RUN: begin
				res_push       = !res_full;
				res.run_last   = run_last;
				res.block_done = run_done;
				res.consumed   = run_done ? ic_next : '0;
			end
			ST_CHECK: begin
				res_push       = match && !res_full;
				res.run_last   = 1'b1;
				res.block_done = chk_done;
				res.consumed   = chk_done ? ic_q : '0;
			end
			default: begin
				res_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			frame_q <= cmd.frame;
			pa_q    <= PROD_W'(eff_oc) * PROD_W'(cfg.in_rate);
			pb_q    <= PROD_W'(eff_ic) * PROD_W'(cfg.out_rate);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			err_q   <= '0;
			oc_q    <= '0;
			ic_q    <= '0;
			fin_q   <= 1'b0;
			reps_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						if (cmd.block_start) begin
							err_q <= start_err;
						end
						oc_q   <= eff_oc;
						ic_q   <= eff_ic;
						fin_q  <= eff_fin;
						reps_q <= '0;
						if (!skip) begin
							if (!cmd.down) begin
								state_q <= ST_RUN;
							end else if (cmd.no_out) begin
								// no output, input still counted
								ic_q <= inc_sat(eff_ic);
							end else begin
								state_q <= ST_CHECK;
							end
						end
					end
				end
				ST_RUN: begin
					if (!res_full) begin
						err_q  <= err_next;
						oc_q   <= oc_next;
						ic_q   <= ic_next;
						reps_q <= reps_next;
						if (run_last) begin
							fin_q   <= run_done;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_CHECK: begin
					if (!match || !res_full) begin
						ic_q    <= inc_sat(ic_q);
						state_q <= ST_IDLE;
						if (match) begin
							oc_q  <= oc_next;
							fin_q <= chk_done;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/nfrc_outq.sv
// ----------------------------------------------------------------------------
// nfrc_outq
// Result queue: holds finished output frames until the consumer pops them.
// ----------------------------------------------------------------------------
`default_nettype none

module nfrc_outq import nfrc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    res_push,
	input  wire result_t res,
	output logic         res_full,
	input  wire logic    pop,
	output logic         empty,
	output result_t      head
);

	result_t               mem_q [RESQ_DEPTH];
	logic [RESQ_PTR_W-1:0] wr_ptr_q;
	logic [RESQ_PTR_W-1:0] rd_ptr_q;
	logic [RESQ_PTR_W:0]   count_q;
	logic                  do_push;
	logic                  do_pop;

	assign res_full = (count_q == (RESQ_PTR_W + 1)'(RESQ_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = res_push && !res_full;
	assign do_pop   = pop && !empty;
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/nearest_frame_rate_converter.sv
// ----------------------------------------------------------------------------
// nearest_frame_rate_converter
// Frame rate converter by repeating or dropping whole stereo frames.
// ----------------------------------------------------------------------------
// Frames enter through a two-entry command queue (push/full) and results
// leave through a four-entry result queue (empty/pop), so either side may
// stall without stopping the other. The back end works on one frame at a
// time. When out_rate >= in_rate a frame leaves the idle state and yields
// one to MAX_REPEATS output frames in the run state, where the single
// error-term adder runs once per output. When out_rate < in_rate the idle
// state registers the two 13x19 products of the output and input indices
// with the rates and the check state compares them. Frames that yield
// nothing (block finished, zero length, zero out_rate with nonzero in_rate)
// stay in the idle state. Configuration writes take effect at the next
// frame and belong in idle periods, with both queues drained.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_frame_rate_converter import nfrc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input frames
	input  wire logic               push,
	output logic                    full,
	input  wire logic [FRAME_W-1:0] frame,
	input  wire logic               block_start,
	// output frames
	output logic                    empty,
	input  wire logic               pop,
	output logic [FRAME_W-1:0]      out_frame,
	output logic                    run_last,
	output logic                    block_done,
	output logic [CNT_W-1:0]        consumed,
	// configuration
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [RATE_W-1:0]  cfg_wdata
);

	cfg_t    cfg_q;
	logic    cmd_valid;
	cmd_t    cmd;
	logic    cmd_pop;
	logic    res_full;
	logic    res_push;
	result_t res;
	result_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_rate      <= RATE_W'(33600);
			cfg_q.out_rate     <= RATE_W'(44100);
			cfg_q.block_frames <= LEN_W'(1024);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IN_RATE:      cfg_q.in_rate      <= cfg_wdata;
				REG_OUT_RATE:     cfg_q.out_rate     <= cfg_wdata;
				REG_BLOCK_FRAMES: cfg_q.block_frames <= cfg_wdata[LEN_W-1:0];
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	nfrc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.frame       (frame),
		.block_start (block_start),
		.cfg         (cfg_q),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop)
	);

	nfrc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	nfrc_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	assign out_frame  = head.frame;
	assign run_last   = head.run_last;
	assign block_done = head.block_done;
	assign consumed   = head.consumed;

endmodule

`default_nettype wire

FILE: src/nfrc_checker.sv
// ----------------------------------------------------------------------------
// nfrc_checker
// Port-level checks of the converter's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module nfrc_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        empty,
	input  wire logic        pop,
	input  wire logic [31:0] out_frame,
	input  wire logic        run_last,
	input  wire logic        block_done,
	input  wire logic [12:0] consumed
);

	logic [46:0] beat;

	assign beat = {out_frame, run_last, block_done, consumed};

	// A waiting beat holds until popped.
	`ASSERT_NEXT(a_hold_beat, clk, arst_n, !empty && !pop, !empty && $stable(beat))

	// The beat that closes a block also closes its run.
	`ASSERT_IMPLIES(a_done_is_last, clk, arst_n, !empty && block_done, run_last)

	// The consumed count shows only on the closing beat.
	`ASSERT_IMPLIES(a_consumed_zero, clk, arst_n, !empty && !block_done, consumed == 13'd0)

endmodule

bind nearest_frame_rate_converter nfrc_checker u_nfrc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.out_frame  (out_frame),
	.run_last   (run_last),
	.block_done (block_done),
	.consumed   (consumed)
);

`default_nettype wire

FILE: verif/tb_nearest_frame_rate_converter.sv
// ----------------------------------------------------------------------------
// tb_nearest_frame_rate_converter
// Self-checking bench for the nearest frame rate converter.
// ----------------------------------------------------------------------------
// Frames are pushed with random gaps while the output side pops with random
// stalls. A behavioral predictor tracks the error term and the block counters,
// lists the output frames each accepted input should yield, and every popped
// beat is compared field by field with the oldest entry. Settings are changed
// only while the block is drained: directed cases first (reset settings, a
// frame before any block start, zero length, zero rates, the repeat cap),
// then random phases of block sequences.
// ----------------------------------------------------------------------------
module tb_nearest_frame_rate_converter import nfrc_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CLK_PERIOD    = 10;
	localparam int          SETTLE_CYCLES = 16;
	localparam int          RANDOM_ITEMS  = 355;
	localparam int unsigned CYCLE_LIMIT   = 1_500_000;
	localparam rate_t       RATE_TOP      = '1;

	class rate_conv_scoreboard;
		localparam longint ERR_HI = (longint'(1) <<< (ERR_W - 1)) - 1;
		localparam longint ERR_LO = -(longint'(1) <<< (ERR_W - 1));

		rate_t                   in_rate;
		rate_t                   out_rate;
		logic [LEN_W-1:0]        block_len;
		logic signed [ERR_W-1:0] err;
		logic [CNT_W-1:0]        out_cnt;
		logic [CNT_W-1:0]        in_cnt;
		bit                      finished;
		result_t                 due_frames[$];
		int                      mismatches;

		function new();
			in_rate    = 19'd33600;
			out_rate   = 19'd44100;
			block_len  = 13'd1024;
			err        = '0;
			out_cnt    = '0;
			in_cnt     = '0;
			finished   = 1'b0;
			mismatches = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [RATE_W-1:0] value);
			case (idx)
				REG_IN_RATE:      in_rate = value;
				REG_OUT_RATE:     out_rate = value;
				REG_BLOCK_FRAMES: block_len = value[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function logic signed [ERR_W-1:0] clamp_err(longint v);
			if (v > ERR_HI)
				return ERR_W'(ERR_HI);
			if (v < ERR_LO)
				return ERR_W'(ERR_LO);
			return ERR_W'(v);
		endfunction

		function logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] c);
			return (c == IN_COUNT_MAX) ? c : c + 1'b1;
		endfunction

		function void add_due(logic [FRAME_W-1:0] f, bit last, bit done,
				logic [CNT_W-1:0] cons);
			result_t r;
			r.frame      = f;
			r.run_last   = last;
			r.block_done = done;
			r.consumed   = done ? cons : '0;
			due_frames.push_back(r);
		endfunction

		// Advance the block state by one accepted frame and queue its beats.
		function void note_frame(logic [FRAME_W-1:0] f, logic bs);
			int unsigned len;
			longint      step_adv;
			longint      step_hold;
			longint      target;
			int          reps;
			bit          adv;
			bit          last;
			bit          done;
			if (bs) begin
				err      = clamp_err(2 * longint'(in_rate) - longint'(out_rate));
				out_cnt  = '0;
				in_cnt   = '0;
				finished = 1'b0;
			end
			len = (block_len > LEN_CAP) ? MAX_BLOCK_FRAMES : block_len;
			if (finished || len == 0 || out_cnt >= len)
				return;
			if (out_rate >= in_rate) begin
				step_adv  = 2 * longint'(in_rate) - 2 * longint'(out_rate);
				step_hold = 2 * longint'(in_rate);
				reps      = 0;
				do begin
					adv = (err >= 0);
					err = clamp_err(longint'(err) + (adv ? step_adv : step_hold));
					out_cnt++;
					reps++;
					last = adv || (reps >= MAX_REPEATS);
					if (last)
						in_cnt = count_up(in_cnt);
					done = (out_cnt >= len);
					if (done) begin
						last     = 1'b1;
						finished = 1'b1;
					end
					add_due(f, last, done, in_cnt);
				end while (!last);
			end else begin
				if (out_rate != 0) begin
					target = longint'(out_cnt) * longint'(in_rate) / longint'(out_rate);
					if (longint'(in_cnt) == target) begin
						out_cnt++;
						done = (out_cnt >= len);
						if (done)
							finished = 1'b1;
						add_due(f, 1'b1, done, CNT_W'(target));
					end
				end
				in_cnt = count_up(in_cnt);
			end
		endfunction

		function void check_out_frame(result_t got);
			result_t want;
			if (due_frames.size() == 0) begin
				$error("unexpected output beat: out_frame %h", got.frame);
				mismatches++;
				return;
			end
			want = due_frames.pop_front();
			if (got.frame !== want.frame) begin
				$error("out_frame: expected %h, actual %h", want.frame, got.frame);
				mismatches++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last: expected %0d, actual %0d", want.run_last, got.run_last);
				mismatches++;
			end
			if (got.block_done !== want.block_done) begin
				$error("block_done: expected %0d, actual %0d", want.block_done,
					got.block_done);
				mismatches++;
			end
			if (got.consumed !== want.consumed) begin
				$error("consumed: expected %0d, actual %0d", want.consumed, got.consumed);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               push        = 1'b0;
	logic               full;
	logic [FRAME_W-1:0] frame       = '0;
	logic               block_start = 1'b0;
	logic               empty;
	logic               pop         = 1'b0;
	logic [FRAME_W-1:0] out_frame;
	logic               run_last;
	logic               block_done;
	logic [CNT_W-1:0]   consumed;
	logic               cfg_we      = 1'b0;
	logic [1:0]         cfg_index   = REG_IN_RATE;
	logic [RATE_W-1:0]  cfg_wdata   = '0;

	rate_conv_scoreboard sb = new();
	bit                  idle_on = 1'b1;
	int                  pop_hold = 0;
	int unsigned         cycles = 0;

	nearest_frame_rate_converter u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.frame       (frame),
		.block_start (block_start),
		.empty       (empty),
		.pop         (pop),
		.out_frame   (out_frame),
		.run_last    (run_last),
		.block_done  (block_done),
		.consumed    (consumed),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Check the beat taken at this edge, then pick pop for the next one.
	always @(posedge clk) begin
		if (arst_n && pop && empty === 1'b0)
			sb.check_out_frame({out_frame, run_last, block_done, consumed});
		if (pop_hold != 0) begin
			pop <= 1'b0;
			pop_hold--;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			pop <= 1'b0;
			pop_hold = $urandom_range(0, 2);
		end else begin
			pop <= 1'b1;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [RATE_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		sb.set_reg(idx, value);
	endtask

	task automatic configure(input rate_t ir, input rate_t orr,
			input logic [RATE_W-1:0] blk);
		write_reg(REG_IN_RATE, ir);
		write_reg(REG_OUT_RATE, orr);
		write_reg(REG_BLOCK_FRAMES, blk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_frame(input logic [FRAME_W-1:0] f, input logic bs);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		push        <= 1'b1;
		frame       <= f;
		block_start <= bs;
		@(posedge clk);
		while (full !== 1'b0)
			@(posedge clk);
		sb.note_frame(f, bs);
	endtask

	// Drop push, wait for every due frame, then let frames that yield
	// nothing leave the pipeline.
	task automatic drain();
		push <= 1'b0;
		while (sb.due_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned       used_items;
		int                n_items;
		rate_t             ir;
		rate_t             orr;
		logic [LEN_W-1:0]  blk;
		logic              bs;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings; first frame arrives before any block start
		send_frame(32'h0000_0000, 1'b0);
		send_frame(32'hFFFF_FFFF, 1'b1);
		send_frame(32'hA5A5_5A5A, 1'b0);
		send_frame(32'h5A5A_A5A5, 1'b0);
		repeat (2) send_frame($urandom, 1'b0);
		drain();

		// drop two of three frames; frames after the block are ignored
		configure(19'd3, 19'd1, 19'd2);
		send_frame($urandom, 1'b1);
		repeat (5) send_frame($urandom, 1'b0);
		drain();

		// zero out_rate: frames counted, nothing produced
		configure(19'd5, 19'd0, 19'd4);
		send_frame($urandom, 1'b1);
		repeat (2) send_frame($urandom, 1'b0);
		drain();

		// both rates zero, then zero in_rate against the repeat cap
		configure(19'd0, 19'd0, 19'd3);
		send_frame($urandom, 1'b1);
		repeat (2) send_frame($urandom, 1'b0);
		drain();
		configure(19'd0, RATE_TOP, 19'd70);
		send_frame($urandom, 1'b1);
		send_frame($urandom, 1'b0);
		drain();

		// top rates equal, block length above the cap with upper data bits set
		configure(RATE_TOP, RATE_TOP, '1);
		send_frame($urandom, 1'b1);
		repeat (2) send_frame($urandom, 1'b0);
		drain();

		// zero block length
		configure(RATE_TOP, 19'd1, 19'd0);
		send_frame($urandom, 1'b1);
		send_frame($urandom, 1'b0);
		drain();

		used_items = 0;
		while (used_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: begin
					ir  = 19'd1;
					orr = RATE_TOP;
				end
				1: begin
					ir  = RATE_TOP;
					orr = 19'd1;
				end
				2: begin
					ir  = RATE_W'($urandom_range(1, RATE_TOP));
					orr = ir;
				end
				3: begin
					ir  = RATE_W'($urandom);
					orr = RATE_W'($urandom);
				end
				4, 5, 6: begin
					ir  = RATE_W'($urandom_range(1, 60000));
					orr = RATE_W'(ir + $urandom_range(0, 3 * ir));
				end
				7, 8: begin
					orr = RATE_W'($urandom_range(1, 60000));
					ir  = RATE_W'(orr + $urandom_range(1, 3 * orr));
				end
				default: begin
					if ($urandom_range(0, 1) == 0) begin
						ir  = RATE_W'($urandom_range(1, RATE_TOP));
						orr = 19'd0;
					end else begin
						ir  = 19'd0;
						orr = RATE_W'($urandom_range(1, RATE_TOP));
					end
				end
			endcase
			case ($urandom_range(0, 15))
				0:       blk = '0;
				1:       blk = LEN_CAP;
				2:       blk = LEN_W'($urandom_range(MAX_BLOCK_FRAMES + 1, 8191));
				default: blk = LEN_W'($urandom_range(1, 40));
			endcase
			configure(ir, orr, {6'($urandom), blk});
			n_items = $urandom_range(20, 48);
			for (int k = 0; k < n_items && used_items < RANDOM_ITEMS; k++) begin
				// mostly whole blocks; now and then a stray frame or an early restart
				if (k == 0)
					bs = ($urandom_range(0, 9) != 0);
				else if (sb.finished)
					bs = ($urandom_range(0, 3) != 0);
				else
					bs = ($urandom_range(0, 29) == 0);
				if (used_items >= RANDOM_ITEMS - 60)
					idle_on = 1'b0;
				send_frame($urandom, bs);
				used_items++;
			end
			drain();
		end

		if (sb.due_frames.size() != 0) begin
			$error("%0d output frames never arrived", sb.due_frames.size());
			sb.mismatches++;
		end
		if (sb.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
